/* rtl/core/acs_pkg.sv */
// shared constants and types for the adc channel scan scheduler
package acs_pkg;

    // default sizes
    localparam int DEF_CHANNELS    = 8;
    localparam int DEF_QUEUE_DEPTH = 4;

    // field widths
    localparam int ACTION_W = 3;
    localparam int CH_W     = 3;
    localparam int FILL_W   = 2;
    localparam int RAW_W    = 16;
    localparam int VALUE_W  = 10;
    localparam int PICK_W   = 4;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_OPEN    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_CLOSE   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SERVICE = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_RESULT  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_WARMUP  = 3'd4;

    // commands from controller to datapath
    typedef struct packed {
        logic load;     // capture the input item
        logic exec;     // commit state and load the result register
    } t_acs_cmd;

endpackage

/* rtl/core/acs_ctrl.sv */
// controller state machine for the scan scheduler
module acs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output acs_pkg::t_acs_cmd o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic out_free;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;

    always_comb begin
        o_cmd.load = s_axis_tvalid && (r_state == ST_IDLE);
        o_cmd.exec = (r_state == ST_EXEC) && out_free;
        n_state    = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.load) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_load_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |-> !o_cmd.load)
        else $error("item captured while previous item still executing");

    a_load_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_EXEC))
        else $error("captured item did not move to execute");

    a_exec_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> r_out_valid)
        else $error("executed item produced no result");

    a_hold_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && r_out_valid && !m_axis_tready) |=> (r_state == ST_EXEC))
        else $error("execute left while result register still occupied");
`endif

endmodule

/* rtl/core/acs_datapath.sv */
// scheduler state, next-channel search and result register
module acs_datapath #(
    parameter int CHANNELS    = acs_pkg::DEF_CHANNELS,
    parameter int QUEUE_DEPTH = acs_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  acs_pkg::t_acs_cmd             i_cmd,
    input  logic                          i_cfg_wr_en,
    input  logic                          i_cfg_wr_data,
    input  logic [acs_pkg::ACTION_W-1:0]  i_action,
    input  logic [acs_pkg::CH_W-1:0]      i_channel,
    input  logic                          i_open_wide,
    input  logic [acs_pkg::FILL_W-1:0]    i_queue_fill,
    input  logic                          i_queue_empty,
    input  logic [acs_pkg::RAW_W-1:0]     i_raw_result,
    output logic                          o_accepted,
    output logic [acs_pkg::CH_W-1:0]      o_request_channel,
    output logic                          o_deliver,
    output logic [acs_pkg::CH_W-1:0]      o_deliver_channel,
    output logic [acs_pkg::VALUE_W-1:0]   o_deliver_value,
    output logic                          o_warming_up,
    output logic [acs_pkg::PICK_W-1:0]    o_next_pick
);

    localparam int IW = $clog2(CHANNELS);
    localparam int PW = $clog2(CHANNELS + 1);
    localparam int SW = PW + 1;

    // first open channel after from, wrapping, from itself last
    function automatic logic [PW-1:0] find_after(input logic [PW-1:0] from,
                                                 input logic [CHANNELS-1:0] mask);
        logic [PW-1:0] res;
        logic [SW-1:0] pos;
        res = PW'(CHANNELS);
        for (int k = CHANNELS; k >= 1; k--) begin
            pos = SW'(from) + SW'(k);
            if (pos >= SW'(CHANNELS)) begin
                pos = pos - SW'(CHANNELS);
            end
            if (mask[pos[IW-1:0]]) begin
                res = pos[PW-1:0];
            end
        end
        return res;
    endfunction

    // captured item
    logic [acs_pkg::ACTION_W-1:0] r_action;
    logic [acs_pkg::CH_W-1:0]     r_channel;
    logic                         r_open_wide;
    logic [acs_pkg::FILL_W-1:0]   r_queue_fill;
    logic                         r_queue_empty;
    logic [acs_pkg::RAW_W-1:0]    r_raw_result;

    // scheduler state
    logic                r_ten_bit;
    logic [CHANNELS-1:0] r_open;
    logic [CHANNELS-1:0] n_open;
    logic [PW-1:0]       r_ptr;
    logic [PW-1:0]       n_ptr;
    logic [CHANNELS-1:0] r_pend;
    logic [CHANNELS-1:0] n_pend;
    logic                r_warm;
    logic                n_warm;

    // result
    logic                         r_accepted;
    logic [acs_pkg::CH_W-1:0]     r_req;
    logic                         r_deliver;
    logic [acs_pkg::CH_W-1:0]     r_dch;
    logic [acs_pkg::VALUE_W-1:0]  r_dval;
    logic                         r_warm_out;
    logic [acs_pkg::PICK_W-1:0]   r_pick;
    logic                         n_accepted;
    logic [acs_pkg::CH_W-1:0]     n_req;
    logic                         n_deliver;
    logic [acs_pkg::CH_W-1:0]     n_dch;
    logic [acs_pkg::VALUE_W-1:0]  n_dval;

    logic                         ch_ok;
    logic [CHANNELS-1:0]          ch_bit;
    logic [acs_pkg::CH_W-1:0]     rch;
    logic                         rch_ok;
    logic [CHANNELS-1:0]          rch_bit;
    logic                         rch_open;
    logic                         q_full;
    logic                         ptr_valid;

    always_comb begin
        ch_ok     = (32'(r_channel) < 32'(CHANNELS));
        ch_bit    = ch_ok ? (CHANNELS'(1) << r_channel) : '0;
        rch       = r_raw_result[acs_pkg::CH_W-1:0];
        rch_ok    = (32'(rch) < 32'(CHANNELS));
        rch_bit   = rch_ok ? (CHANNELS'(1) << rch) : '0;
        rch_open  = |(r_open & rch_bit);
        q_full    = (r_queue_fill == acs_pkg::FILL_W'(QUEUE_DEPTH - 1)) && !r_queue_empty;
        ptr_valid = (32'(r_ptr) < 32'(CHANNELS));

        n_open     = r_open;
        n_ptr      = r_ptr;
        n_pend     = r_pend;
        n_warm     = r_warm;
        n_accepted = 1'b0;
        n_req      = '0;
        n_deliver  = 1'b0;
        n_dch      = '0;
        n_dval     = '0;

        case (r_action)
            acs_pkg::ACT_OPEN: begin
                if ((r_open_wide == r_ten_bit) && ch_ok) begin
                    n_open     = r_open | ch_bit;
                    n_accepted = 1'b1;
                    if (!ptr_valid) begin
                        n_ptr = PW'(r_channel);
                    end
                end
            end
            acs_pkg::ACT_CLOSE: begin
                if (ch_ok) begin
                    n_open = r_open & ~ch_bit;
                    n_pend = r_pend & ~ch_bit;
                    if (r_ptr == PW'(r_channel)) begin
                        n_ptr = find_after(PW'(r_channel), n_open);
                    end
                end
            end
            acs_pkg::ACT_SERVICE: begin
                if (ptr_valid && !q_full) begin
                    n_accepted = 1'b1;
                    n_req      = acs_pkg::CH_W'(r_ptr);
                    n_ptr      = find_after(r_ptr, r_open);
                end
            end
            acs_pkg::ACT_RESULT: begin
                if (rch_open) begin
                    n_deliver = 1'b1;
                    n_dch     = rch;
                    n_dval    = r_ten_bit ? r_raw_result[15:6] : {2'b00, r_raw_result[15:8]};
                    n_pend    = r_pend & ~rch_bit;
                end
                if (r_warm && ((n_pend & r_open) == '0)) begin
                    n_warm = 1'b0;
                end
            end
            acs_pkg::ACT_WARMUP: begin
                if (r_ten_bit) begin
                    n_pend = r_open;
                    n_warm = 1'b1;
                end
            end
            default: begin
                n_open = r_open;
            end
        endcase
    end

    // input capture and result register load, payload only
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action      <= i_action;
            r_channel     <= i_channel;
            r_open_wide   <= i_open_wide;
            r_queue_fill  <= i_queue_fill;
            r_queue_empty <= i_queue_empty;
            r_raw_result  <= i_raw_result;
        end
        if (i_cmd.exec) begin
            r_accepted <= n_accepted;
            r_req      <= n_req;
            r_deliver  <= n_deliver;
            r_dch      <= n_dch;
            r_dval     <= n_dval;
            r_warm_out <= n_warm;
            r_pick     <= acs_pkg::PICK_W'(n_ptr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ten_bit <= 1'b1;
            r_open    <= '0;
            r_ptr     <= PW'(CHANNELS);
            r_pend    <= '0;
            r_warm    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_ten_bit <= i_cfg_wr_data;
            end
            if (i_cmd.exec) begin
                r_open <= n_open;
                r_ptr  <= n_ptr;
                r_pend <= n_pend;
                r_warm <= n_warm;
            end
        end
    end

    assign o_accepted        = r_accepted;
    assign o_request_channel = r_req;
    assign o_deliver         = r_deliver;
    assign o_deliver_channel = r_dch;
    assign o_deliver_value   = r_dval;
    assign o_warming_up      = r_warm_out;
    assign o_next_pick       = r_pick;

endmodule

/* rtl/core/adc_channel_scan_scheduler_top.sv */
// top level of the round-robin adc channel scan scheduler
//
// input channel (s_axis): one item is one action; tuser carries the action code
//   (open, close, service, conversion result, start warmup), tdata the operands
// output channel (m_axis): exactly one result item per input item, in order
// config: i_cfg_wr_en / i_cfg_wr_data write ten_bit_mode (1 = 10-bit results
//   and opens); write only while the block is idle
// timing: an item is captured at its accept edge, executed on the next edge
//   into the result register, so m_axis_tvalid rises one cycle after accept
// throughput: one item every 2 cycles, set by the capture/execute controller;
//   the next-channel search is a rotate and priority pick within the execute cycle
// stall: while a result waits on m_axis_tready the next item can still be
//   captured; it then holds in execute until the result register frees up
// reset (i_rst_n low, synchronous): no channel open, next pick = none,
//   warmup idle, ten_bit_mode = 1, output empty
module adc_channel_scan_scheduler_top #(
    parameter int CHANNELS    = acs_pkg::DEF_CHANNELS,
    parameter int QUEUE_DEPTH = acs_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_wr_en,
    input  logic                            i_cfg_wr_data,  // ten_bit_mode
    // input item stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // channel[2:0], open_wide[3], queue_fill[5:4], queue_empty[6],
    // raw_result[22:7], zero pad [23]
    input  logic [acs_pkg::S_DATA_W-1:0]    s_axis_tdata,
    // action[2:0]
    input  logic [acs_pkg::ACTION_W-1:0]    s_axis_tuser,
    // result item stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // accepted[0], request_channel[3:1], deliver[4], deliver_channel[7:5],
    // deliver_value[17:8], warming_up[18], next_pick[22:19], zero pad [23]
    output logic [acs_pkg::M_DATA_W-1:0]    m_axis_tdata
);

    acs_pkg::t_acs_cmd cmd;

    logic                          accepted;
    logic [acs_pkg::CH_W-1:0]      request_channel;
    logic                          deliver;
    logic [acs_pkg::CH_W-1:0]      deliver_channel;
    logic [acs_pkg::VALUE_W-1:0]   deliver_value;
    logic                          warming_up;
    logic [acs_pkg::PICK_W-1:0]    next_pick;

    // capture / execute sequencing and output valid
    acs_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_cmd         (cmd)
    );

    // channel mask, pointer, warmup tracking and result register
    acs_datapath #(
        .CHANNELS    (CHANNELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_action          (s_axis_tuser),
        .i_channel         (s_axis_tdata[2:0]),
        .i_open_wide       (s_axis_tdata[3]),
        .i_queue_fill      (s_axis_tdata[5:4]),
        .i_queue_empty     (s_axis_tdata[6]),
        .i_raw_result      (s_axis_tdata[22:7]),
        .o_accepted        (accepted),
        .o_request_channel (request_channel),
        .o_deliver         (deliver),
        .o_deliver_channel (deliver_channel),
        .o_deliver_value   (deliver_value),
        .o_warming_up      (warming_up),
        .o_next_pick       (next_pick)
    );

    // pack result fields, lowest first
    assign m_axis_tdata = {1'b0, next_pick, warming_up, deliver_value, deliver_channel,
                           deliver, request_channel, accepted};

endmodule

/* tb/tb.sv */
// self-checking testbench for the adc channel scan scheduler top level
module tb;

    localparam int NCH = acs_pkg::DEF_CHANNELS;
    localparam logic [acs_pkg::PICK_W-1:0]   NO_PICK      = acs_pkg::PICK_W'(NCH);
    localparam logic [acs_pkg::FILL_W-1:0]   FILL_FULL    =
        acs_pkg::FILL_W'(acs_pkg::DEF_QUEUE_DEPTH - 1);
    localparam logic [acs_pkg::ACTION_W-1:0] ACT_SPARE_LO = 3'd5;
    localparam logic [acs_pkg::ACTION_W-1:0] ACT_SPARE_HI = 3'd7;
    localparam int RANDOM_ITEMS = 200;
    localparam int MAX_CYCLES   = 400000;

    typedef struct packed {
        logic [acs_pkg::ACTION_W-1:0] action;
        logic [acs_pkg::CH_W-1:0]     channel;
        logic                         wide;
        logic [acs_pkg::FILL_W-1:0]   fill;
        logic                         empty;
        logic [acs_pkg::RAW_W-1:0]    raw;
    } t_scan_action;

    typedef struct packed {
        logic                         accepted;
        logic [acs_pkg::CH_W-1:0]     req_ch;
        logic                         deliver;
        logic [acs_pkg::CH_W-1:0]     dlv_ch;
        logic [acs_pkg::VALUE_W-1:0]  dlv_value;
        logic                         warming;
        logic [acs_pkg::PICK_W-1:0]   next_pick;
    } t_scan_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_wr_en = 1'b0;
    logic                         i_cfg_wr_data = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [acs_pkg::S_DATA_W-1:0] s_axis_tdata = '0;
    logic [acs_pkg::ACTION_W-1:0] s_axis_tuser = '0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [acs_pkg::M_DATA_W-1:0] m_axis_tdata;

    adc_channel_scan_scheduler_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // scheduler state as predicted
    logic [NCH-1:0]             open_mask_m;
    logic [acs_pkg::PICK_W-1:0] next_ptr_m;
    logic [NCH-1:0]             warm_pend_m;
    logic                       warm_act_m;
    logic                       ten_bit_m;

    t_scan_action pending_actions[$];
    t_scan_result expected_results[$];
    t_scan_action cur_offer;
    bit           offer_taken = 1'b0;

    int  n_queued = 0, n_accepted = 0, n_checked = 0, n_err = 0;
    int  n_req = 0, n_dlv = 0;
    bit  idle_on = 1'b1;
    int  hold_asked = 0, hold_served = 0, hold_left = 0;
    int  send_gap = 0, take_gap = 0;

    // stimulus side bookkeeping
    logic           cur_mode = 1'b1;
    logic [NCH-1:0] gen_open = '0;

    // round-robin search: first open channel after 'from', 'from' itself last
    function automatic logic [acs_pkg::PICK_W-1:0] next_open_after(logic [NCH-1:0] mask,
                                                                   int from);
        int c;
        for (int k = 1; k <= NCH; k++) begin
            c = (from + k) % NCH;
            if (mask[c])
                return acs_pkg::PICK_W'(c);
        end
        return NO_PICK;
    endfunction

    function automatic t_scan_result schedule_step(t_scan_action a);
        t_scan_result             r;
        logic [acs_pkg::CH_W-1:0] rch;
        r = '0;
        rch = a.raw[acs_pkg::CH_W-1:0];
        case (a.action)
            acs_pkg::ACT_OPEN: begin
                // refused when the requested width does not match the mode
                if (a.wide == ten_bit_m) begin
                    open_mask_m[a.channel] = 1'b1;
                    if (next_ptr_m >= NO_PICK)
                        next_ptr_m = {1'b0, a.channel};
                    r.accepted = 1'b1;
                end
            end
            acs_pkg::ACT_CLOSE: begin
                open_mask_m[a.channel] = 1'b0;
                warm_pend_m[a.channel] = 1'b0;
                if (next_ptr_m == {1'b0, a.channel})
                    next_ptr_m = next_open_after(open_mask_m, int'(a.channel));
            end
            acs_pkg::ACT_SERVICE: begin
                if (next_ptr_m < NO_PICK && !(a.fill == FILL_FULL && !a.empty)) begin
                    r.accepted = 1'b1;
                    r.req_ch = next_ptr_m[acs_pkg::CH_W-1:0];
                    next_ptr_m = next_open_after(open_mask_m, int'(next_ptr_m));
                end
            end
            acs_pkg::ACT_RESULT: begin
                if (open_mask_m[rch]) begin
                    r.deliver = 1'b1;
                    r.dlv_ch = rch;
                    r.dlv_value = ten_bit_m ? a.raw[15:6] : {2'b00, a.raw[15:8]};
                    warm_pend_m[rch] = 1'b0;
                end
                // warmup end is checked on every conversion result
                if (warm_act_m && (warm_pend_m & open_mask_m) == '0)
                    warm_act_m = 1'b0;
            end
            acs_pkg::ACT_WARMUP: begin
                if (ten_bit_m) begin
                    warm_pend_m = open_mask_m;
                    warm_act_m = 1'b1;
                end
            end
            default: ;
        endcase
        r.warming = warm_act_m;
        r.next_pick = next_ptr_m;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            n_err++;
        end
    endfunction

    // prediction on accepted items, comparison on accepted results
    always @(posedge i_clk) begin
        t_scan_result got, want;
        if (!i_rst_n) begin
            open_mask_m = '0;
            next_ptr_m = NO_PICK;
            warm_pend_m = '0;
            warm_act_m = 1'b0;
            ten_bit_m = 1'b1;
            offer_taken = 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_checked++;
                got.accepted = m_axis_tdata[0];
                got.req_ch = m_axis_tdata[3:1];
                got.deliver = m_axis_tdata[4];
                got.dlv_ch = m_axis_tdata[7:5];
                got.dlv_value = m_axis_tdata[17:8];
                got.warming = m_axis_tdata[18];
                got.next_pick = m_axis_tdata[22:19];
                if (expected_results.size() == 0) begin
                    $error("result item with nothing expected: %h", m_axis_tdata);
                    n_err++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("accepted", want.accepted, got.accepted);
                    check_field("request_channel", want.req_ch, got.req_ch);
                    check_field("deliver", want.deliver, got.deliver);
                    check_field("deliver_channel", want.dlv_ch, got.dlv_ch);
                    check_field("deliver_value", want.dlv_value, got.dlv_value);
                    check_field("warming_up", want.warming, got.warming);
                    check_field("next_pick", want.next_pick, got.next_pick);
                end
            end
            if (i_cfg_wr_en)
                ten_bit_m = i_cfg_wr_data;
            offer_taken = s_axis_tvalid && s_axis_tready;
            if (offer_taken) begin
                want = schedule_step(cur_offer);
                expected_results.push_back(want);
                n_accepted++;
                if (cur_offer.action == acs_pkg::ACT_SERVICE && want.accepted)
                    n_req++;
                if (want.deliver)
                    n_dlv++;
            end
        end
    end

    // sender: holds an offered item until taken, idles in bursts of random length while idle_on
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !offer_taken) begin
            // keep offering the same item
        end else if (send_gap > 0) begin
            send_gap--;
            s_axis_tvalid <= 1'b0;
        end else if (pending_actions.size() == 0) begin
            s_axis_tvalid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 14);
            s_axis_tvalid <= 1'b0;
        end else begin
            cur_offer = pending_actions.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= {1'b0, cur_offer.raw, cur_offer.empty, cur_offer.fill,
                             cur_offer.wide, cur_offer.channel};
            s_axis_tuser <= cur_offer.action;
        end
    end

    // receiver: random stalls while idle_on, plus a long hold-off on request so the block backs up
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left = $urandom_range(60, 100);
            m_axis_tready <= 1'b0;
        end else if (take_gap > 0) begin
            take_gap--;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            take_gap = $urandom_range(0, 14);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic queue_action(logic [acs_pkg::ACTION_W-1:0] action,
                                logic [acs_pkg::CH_W-1:0] channel,
                                logic wide, logic [acs_pkg::FILL_W-1:0] fill, logic empty,
                                logic [acs_pkg::RAW_W-1:0] raw);
        t_scan_action a;
        a = '{action: action, channel: channel, wide: wide, fill: fill, empty: empty,
              raw: raw};
        if (action == acs_pkg::ACT_OPEN && wide == cur_mode)
            gen_open[channel] = 1'b1;
        if (action == acs_pkg::ACT_CLOSE)
            gen_open[channel] = 1'b0;
        pending_actions.push_back(a);
        n_queued++;
    endtask

    // mostly well-formed traffic: opens in the right width, results for open channels
    task automatic queue_random_action();
        int roll;
        int pick;
        logic [acs_pkg::ACTION_W-1:0] action;
        logic [acs_pkg::CH_W-1:0]     channel;
        logic                         wide;
        logic [acs_pkg::RAW_W-1:0]    raw;
        roll = $urandom_range(0, 99);
        channel = acs_pkg::CH_W'($urandom_range(0, NCH - 1));
        wide = 1'($urandom_range(0, 1));
        raw = acs_pkg::RAW_W'($urandom_range(0, 16'hffff));
        if (roll < 20) begin
            action = acs_pkg::ACT_OPEN;
            if ($urandom_range(0, 6) != 0)
                wide = cur_mode;
        end else if (roll < 32) begin
            action = acs_pkg::ACT_CLOSE;
        end else if (roll < 57) begin
            action = acs_pkg::ACT_SERVICE;
        end else if (roll < 90) begin
            action = acs_pkg::ACT_RESULT;
            if (gen_open != '0 && $urandom_range(0, 3) != 0) begin
                do pick = $urandom_range(0, NCH - 1); while (!gen_open[pick]);
                raw[acs_pkg::CH_W-1:0] = acs_pkg::CH_W'(pick);
            end
        end else if (roll < 96) begin
            action = acs_pkg::ACT_WARMUP;
        end else begin
            action = acs_pkg::ACTION_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        end
        queue_action(action, channel, wide, acs_pkg::FILL_W'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)), raw);
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || n_checked != n_accepted)
            @(negedge i_clk);
        // settle time before touching the mode register
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_mode(logic mode);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= mode;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_mode = mode;
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, 10-bit mode after reset
        queue_action(acs_pkg::ACT_SERVICE, 3'd0, 1'b1, 2'd0, 1'b1, 16'h0000); // nothing open
        queue_action(acs_pkg::ACT_RESULT, 3'd0, 1'b1, 2'd0, 1'b0, 16'hffff);  // closed channel
        queue_action(acs_pkg::ACT_OPEN, 3'd0, 1'b0, 2'd0, 1'b0, 16'h0000);    // wrong width
        queue_action(acs_pkg::ACT_OPEN, 3'd0, 1'b1, 2'd0, 1'b0, 16'h0000);
        queue_action(acs_pkg::ACT_OPEN, 3'd7, 1'b1, 2'd0, 1'b0, 16'h0000);
        queue_action(acs_pkg::ACT_OPEN, 3'd3, 1'b1, 2'd0, 1'b0, 16'h0000);
        queue_action(acs_pkg::ACT_WARMUP, 3'd0, 1'b0, 2'd0, 1'b0, 16'h0000);
        queue_action(acs_pkg::ACT_SERVICE, 3'd0, 1'b1, FILL_FULL, 1'b0, 16'h0000); // full
        queue_action(acs_pkg::ACT_SERVICE, 3'd0, 1'b1, FILL_FULL, 1'b1, 16'h0000);
        queue_action(acs_pkg::ACT_SERVICE, 3'd7, 1'b0, 2'd0, 1'b0, 16'h0000);
        queue_action(acs_pkg::ACT_RESULT, 3'd0, 1'b0, 2'd0, 1'b0, 16'hffff);  // ch 7, max value
        queue_action(acs_pkg::ACT_RESULT, 3'd0, 1'b0, 2'd0, 1'b0, 16'h0003);  // ch 3, zero value
        queue_action(acs_pkg::ACT_CLOSE, 3'd0, 1'b0, 2'd0, 1'b0, 16'h0000);   // pending ch 0
        queue_action(acs_pkg::ACT_RESULT, 3'd0, 1'b0, 2'd0, 1'b0, 16'h5a45);  // closed ch 5
        queue_action(ACT_SPARE_LO, 3'd7, 1'b1, 2'd3, 1'b1, 16'hffff);
        queue_action(ACT_SPARE_HI, 3'd0, 1'b0, 2'd0, 1'b0, 16'h0000);
        queue_action(acs_pkg::ACT_CLOSE, 3'd3, 1'b0, 2'd0, 1'b0, 16'h0000);
        queue_action(acs_pkg::ACT_CLOSE, 3'd7, 1'b0, 2'd0, 1'b0, 16'h0000);   // pick none
        wait_drained();

        // directed, 8-bit mode
        write_mode(1'b0);
        @(posedge i_clk);
        queue_action(acs_pkg::ACT_OPEN, 3'd2, 1'b1, 2'd0, 1'b0, 16'h0000);    // wrong width
        queue_action(acs_pkg::ACT_OPEN, 3'd2, 1'b0, 2'd0, 1'b0, 16'h0000);
        queue_action(acs_pkg::ACT_WARMUP, 3'd0, 1'b0, 2'd0, 1'b0, 16'h0000);  // ignored
        queue_action(acs_pkg::ACT_RESULT, 3'd0, 1'b0, 2'd0, 1'b0, 16'hff02);
        queue_action(acs_pkg::ACT_SERVICE, 3'd0, 1'b0, 2'd2, 1'b0, 16'h0000);
        queue_action(acs_pkg::ACT_CLOSE, 3'd2, 1'b0, 2'd0, 1'b0, 16'h0000);
        wait_drained();

        // random, 10-bit, with one long output stall at the start
        write_mode(1'b1);
        @(posedge i_clk);
        hold_asked++;
        repeat (RANDOM_ITEMS) queue_random_action();
        wait_drained();

        // random, 8-bit
        write_mode(1'b0);
        @(posedge i_clk);
        repeat (RANDOM_ITEMS) queue_random_action();
        wait_drained();

        // random, 10-bit, full rate on both sides
        write_mode(1'b1);
        @(posedge i_clk);
        idle_on = 1'b0;
        send_gap = 0;
        take_gap = 0;
        repeat (RANDOM_ITEMS) queue_random_action();
        wait_drained();
        repeat (10) @(negedge i_clk);

        if (expected_results.size() != 0) begin
            $error("%0d expected result items never arrived", expected_results.size());
            n_err++;
        end
        $display("covered %0d items in both result widths, with stalls and one long hold-off",
                 n_accepted);
        $display("%0d channel requests issued, %0d conversion values delivered", n_req, n_dlv);
        if (n_err == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #(MAX_CYCLES * 10);
        $display("Mismatches found");
        $finish;
    end

endmodule
